@@ design/bcdlh_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdlh_pkg
// Shared constants and helper functions for the packed BCD encoder with a
// length header: widths, pipeline split and the double-dabble step.
// ----------------------------------------------------------------------------
package bcdlh_pkg;

    // Binary input and BCD result widths
    localparam int VALUE_W        = 32;
    localparam int DIGITS         = 10;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int BYTE_W         = 8;
    localparam int MAX_PAIRS      = DIGITS / 2;
    localparam int PAIRS_W        = $clog2(MAX_PAIRS + 1);

    // Pipeline split: bits of the binary value consumed per stage
    localparam int BITS_PER_STAGE = 4;
    localparam int STAGES         = VALUE_W / BITS_PER_STAGE;

    // Largest digit that passes through a step without the +3 correction
    localparam logic [3:0] DIGIT_KEEP_MAX = 4'd4;
    localparam logic [3:0] DIGIT_ADJ      = 4'd3;

    // One double-dabble step: correct every digit above four, shift in a bit
    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0] bcd,
        input logic             bit_in
    );
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd[4*d +: 4] > DIGIT_KEEP_MAX) begin
                adj[4*d +: 4] = bcd[4*d +: 4] + DIGIT_ADJ;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    // Number of packed bytes needed: highest nonzero digit pair, at least one
    function automatic logic [PAIRS_W-1:0] pair_count(input logic [BCD_W-1:0] bcd);
        logic [PAIRS_W-1:0] cnt;
        cnt = PAIRS_W'(1);
        for (int p = 1; p < MAX_PAIRS; p++) begin
            if (bcd[BYTE_W*p +: BYTE_W] != '0) begin
                cnt = PAIRS_W'(p + 1);
            end
        end
        return cnt;
    endfunction

endpackage

@@ design/binary_to_packed_bcd_length_header_top.sv @@
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_length_header_top
// Encodes a 32-bit unsigned word as a byte count followed by packed BCD
// bytes, most significant pair first, with last marking the final byte.
// ----------------------------------------------------------------------------
// The byte serializer takes a new number only as it emits the last byte of the
//   current one; the eight-stage conversion pipeline accepts a word per cycle when not stalled.
// Reset (synchronous, active low) empties the pipeline and the serializer.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_length_header_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bcdlh_pkg::VALUE_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bcdlh_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                          o_last
);

    localparam int BCD_W   = bcdlh_pkg::BCD_W;
    localparam int BYTE_W  = bcdlh_pkg::BYTE_W;
    localparam int PAIRS_W = bcdlh_pkg::PAIRS_W;

    logic               pipe_rdy;
    logic               pipe_vld;
    logic [BCD_W-1:0]   pipe_bcd;
    logic               take;
    logic               adv;
    logic               done;
    logic [PAIRS_W-1:0] ld_pairs;
    logic [5:0]         ld_shift;

    logic               r_busy,  n_busy;
    logic [PAIRS_W-1:0] r_pairs, n_pairs;
    logic [PAIRS_W-1:0] r_idx,   n_idx;
    logic [BCD_W-1:0]   r_sh,    n_sh;
    logic               r_o_vld, n_o_vld;
    logic [BYTE_W-1:0]  r_o_byte, n_o_byte;
    logic               r_o_last, n_o_last;

    bcdlh_dabble_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in_valid),
        .i_value (i_value),
        .o_rdy   (pipe_rdy),
        .o_vld   (pipe_vld),
        .o_bcd   (pipe_bcd),
        .i_take  (take)
    );

    assign o_in_stall = !pipe_rdy;

    // Serializer handshake: output register free, current number finishing
    assign adv  = !r_o_vld || !i_out_stall;
    assign done = r_busy && (r_idx == r_pairs);
    assign take = adv && (!r_busy || done);

    // Left-align the leading pair so bytes leave from the top
    assign ld_pairs = bcdlh_pkg::pair_count(pipe_bcd);
    assign ld_shift = {3'(PAIRS_W'(bcdlh_pkg::MAX_PAIRS) - ld_pairs), 3'b000};

    // Next-state for the serializer and output register
    always_comb begin
        n_busy   = r_busy;
        n_pairs  = r_pairs;
        n_idx    = r_idx;
        n_sh     = r_sh;
        n_o_vld  = r_o_vld;
        n_o_byte = r_o_byte;
        n_o_last = r_o_last;
        if (adv) begin
            n_o_vld = r_busy;
            if (r_busy) begin
                n_o_last = (r_idx == r_pairs);
                if (r_idx == '0) begin
                    n_o_byte = BYTE_W'(r_pairs);
                end else begin
                    n_o_byte = r_sh[BCD_W-1 -: BYTE_W];
                    n_sh     = {r_sh[BCD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                end
                n_idx = r_idx + PAIRS_W'(1);
            end
        end
        if (take && pipe_vld) begin
            n_busy  = 1'b1;
            n_pairs = ld_pairs;
            n_idx   = '0;
            n_sh    = pipe_bcd << ld_shift;
        end else if (take) begin
            n_busy = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_o_vld <= n_o_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pairs  <= n_pairs;
        r_idx    <= n_idx;
        r_sh     <= n_sh;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
    end

    assign o_out_valid = r_o_vld;
    assign o_out_byte  = r_o_byte;
    assign o_last      = r_o_last;

endmodule

@@ design/bcdlh_dabble_pipe.sv @@
// ----------------------------------------------------------------------------
// bcdlh_dabble_pipe
// Binary to BCD conversion pipeline. Each stage runs four double-dabble
// steps; a stage moves forward when it is empty or its successor moves.
// ----------------------------------------------------------------------------
module bcdlh_dabble_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [bcdlh_pkg::VALUE_W-1:0] i_value,
    output logic                          o_rdy,
    output logic                          o_vld,
    output logic [bcdlh_pkg::BCD_W-1:0]   o_bcd,
    input  logic                          i_take
);

    localparam int NS = bcdlh_pkg::STAGES;
    localparam int BW = bcdlh_pkg::BITS_PER_STAGE;

    logic                          r_vld [NS];
    logic [bcdlh_pkg::VALUE_W-1:0] r_bin [NS];
    logic [bcdlh_pkg::BCD_W-1:0]   r_bcd [NS];
    logic [bcdlh_pkg::VALUE_W-1:0] n_bin [NS];
    logic [bcdlh_pkg::BCD_W-1:0]   n_bcd [NS];
    logic                          stg_rdy [NS+1];

    // Ready chain, from the consumer back to the input
    assign stg_rdy[NS] = i_take;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                          in_vld;
        logic [bcdlh_pkg::VALUE_W-1:0] in_bin;
        logic [bcdlh_pkg::BCD_W-1:0]   in_bcd;

        if (s == 0) begin : g_first
            assign in_vld = i_vld;
            assign in_bin = i_value;
            assign in_bcd = '0;
        end else begin : g_next
            assign in_vld = r_vld[s-1];
            assign in_bin = r_bin[s-1];
            assign in_bcd = r_bcd[s-1];
        end

        assign stg_rdy[s] = !r_vld[s] || stg_rdy[s+1];

        // Four dependent shift/correct steps
        always_comb begin
            logic [bcdlh_pkg::VALUE_W-1:0] b;
            logic [bcdlh_pkg::BCD_W-1:0]   d;
            b = in_bin;
            d = in_bcd;
            for (int j = 0; j < BW; j++) begin
                d = bcdlh_pkg::dabble_step(d, b[bcdlh_pkg::VALUE_W-1]);
                b = {b[bcdlh_pkg::VALUE_W-2:0], 1'b0};
            end
            n_bin[s] = b;
            n_bcd[s] = d;
        end

        // Stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (stg_rdy[s]) begin
                r_vld[s] <= in_vld;
            end
        end

        // Stage payload
        always_ff @(posedge i_clk) begin
            if (stg_rdy[s] && in_vld) begin
                r_bin[s] <= n_bin[s];
                r_bcd[s] <= n_bcd[s];
            end
        end
    end

    assign o_rdy = stg_rdy[0];
    assign o_vld = r_vld[NS-1];
    assign o_bcd = r_bcd[NS-1];

endmodule

@@ design/bcdlh_checker.sv @@
// ----------------------------------------------------------------------------
// bcdlh_checker
// Port-level checks on the encoder output: reset, hold under stall, digit
// range and the count byte that opens every number.
// ----------------------------------------------------------------------------
module bcdlh_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [bcdlh_pkg::VALUE_W-1:0] i_value,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [bcdlh_pkg::BYTE_W-1:0]  o_out_byte,
    input logic                          o_last
);

    logic out_acc;
    logic r_at_head;

    assign out_acc = o_out_valid && !i_out_stall;

    // Next accepted word opens a number (after reset or after a last word)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_head <= 1'b1;
        end else if (out_acc) begin
            r_at_head <= o_last;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("stalled output word changed");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_byte[7:4] <= 4'd9) && (o_out_byte[3:0] <= 4'd9))
        else $error("output nibble is not a decimal digit");

    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_at_head |->
            !o_last && (o_out_byte >= 8'd1) && (o_out_byte <= 8'd5))
        else $error("number does not open with a count of 1 to 5");

    // Input side is observed only to keep the port list complete
    logic unused_in;
    assign unused_in = i_in_valid ^ o_in_stall ^ (^i_value);

endmodule

bind binary_to_packed_bcd_length_header_top bcdlh_checker u_bcdlh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_value     (i_value),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);
